// ----- src/spq_pkg.sv -----
// Shared widths, codes and types for the sorted priority queue.
package spq_pkg;

	localparam int KeyW          = 16;
	localparam int StatW         = 2;
	localparam int FillW         = 5;
	localparam int DefQueueDepth = 16;

	typedef enum logic [StatW-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} spq_mode_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic            ins;
		logic            rem;
		logic [KeyW-1:0] key;
	} spq_cmd_t;

endpackage

// ----- src/spq_cell.sv -----
// One cell of the sorted row: holds a key and shifts it toward either neighbor.
module spq_cell
	import spq_pkg::*;
(
	input  logic            clk,
	input  spq_cmd_t        cmd,
	input  logic            occupied,
	input  logic            prev_ge,
	input  logic [KeyW-1:0] prev_key,
	input  logic [KeyW-1:0] next_key,
	output logic [KeyW-1:0] key,
	output logic            ge
);

	logic [KeyW-1:0] key_q;
	logic [KeyW-1:0] key_d;

	// Held key stays ahead of the new one when greater or equal (arrival order on ties).
	assign ge  = occupied && (key_q >= cmd.key);
	assign key = key_q;

	always_comb begin
		key_d = key_q;
		if (cmd.rem) begin
			key_d = next_key;
		end else if (cmd.ins && !ge) begin
			key_d = prev_ge ? cmd.key : prev_key;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

// ----- src/sorted_priority_queue_unit.sv -----
// Top level of the sorted priority queue: cell row, fill count and output register.
//
// Bounded priority queue of QUEUE_DEPTH 16-bit keys, kept sorted with the largest key in
// front by a row of cells that all compare against the incoming key and shift in the same
// cycle. One item (insert or remove) is taken every clock cycle while ready; its result
// is loaded into the output register at the transfer. Input is ready whenever the output
// register is empty or is being taken in the same cycle, so throughput is limited only by
// downstream back-pressure. An insert into a full queue or a remove from an empty queue
// leaves the contents unchanged and reports its status. Equal keys leave in arrival order.
module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DefQueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] key_value
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] removed_value, [20:16] fill_level, zero pad
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  count_d;
	logic             m_tvalid_q;
	spq_status_t      status_q;
	spq_status_t      status_d;
	logic [KeyW-1:0]  removed_q;
	logic [KeyW-1:0]  removed_d;
	logic [FillW-1:0] fill_q;
	logic [31:0]      count_ext;
	logic             accept;
	logic             is_full;
	logic             is_empty;
	spq_cmd_t         cmd;

	logic [KeyW-1:0]  cell_key [QUEUE_DEPTH];
	logic             cell_ge  [QUEUE_DEPTH];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_full  = (count_q == CntW'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		cmd       = '0;
		cmd.key   = s_tdata[KeyW-1:0];
		count_d   = count_q;
		status_d  = ST_DONE;
		removed_d = '0;
		if (accept) begin
			if (spq_mode_t'(s_tuser) == MODE_INSERT) begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					count_d = count_q + CntW'(1);
				end
			end else begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					cmd.rem   = 1'b1;
					removed_d = cell_key[0];
					count_d   = count_q - CntW'(1);
				end
			end
		end
	end

	assign count_ext = 32'(count_d);

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic            occ;
			logic            p_ge;
			logic [KeyW-1:0] p_key;
			logic [KeyW-1:0] n_key;

			assign occ = (CntW'(gi) < count_q);
			if (gi == 0) begin : g_head
				assign p_ge  = 1'b1;
				assign p_key = cmd.key;
			end else begin : g_body
				assign p_ge  = cell_ge[gi-1];
				assign p_key = cell_key[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign n_key = cell_key[gi];
			end else begin : g_mid
				assign n_key = cell_key[gi+1];
			end

			spq_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occupied (occ),
				.prev_ge  (p_ge),
				.prev_key (p_key),
				.next_key (n_key),
				.key      (cell_key[gi]),
				.ge       (cell_ge[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload of the output register; load on every input transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			removed_q <= removed_d;
			fill_q    <= count_ext[FillW-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, fill_q, removed_q};
	assign m_tuser  = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == MODE_INSERT && is_full)
		|=> (m_tvalid && status_q == ST_FULL && count_q == $past(count_q)))
		else $error("insert into full queue not refused");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == MODE_REMOVE && !is_empty)
		|=> (status_q == ST_DONE && count_q == $past(count_q) - CntW'(1)))
		else $error("remove did not drop one entry");

	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count changed without a transfer");

endmodule

// ----- tb/spq_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the sorted priority queue: tracks both streams, predicts and compares.
module spq_checker
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DefQueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] key_value
	input  logic        s_tuser,   // [0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [15:0] removed_value, [20:16] fill_level, zero pad
	input  logic [1:0]  m_tuser,   // [1:0] status
	output int          fail_count,
	output int          pending,
	output int          result_count,
	output int          full_count,
	output int          empty_count
);

	typedef struct packed {
		spq_status_t      status;
		logic [KeyW-1:0]  taken;
		logic [FillW-1:0] fill;
	} queue_result_t;

	logic [KeyW-1:0] held_keys [QUEUE_DEPTH];
	int              held;
	queue_result_t   expected_q [$];

	// Apply one insert or remove to the shadow queue and return the result it should give.
	function automatic queue_result_t apply_item(input spq_mode_t mode,
	                                             input logic [KeyW-1:0] key);
		queue_result_t r;
		int            pos;
		r.status = ST_DONE;
		r.taken  = '0;
		if (mode == MODE_INSERT) begin
			if (held >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// go behind every key that is greater or equal
				pos = 0;
				while (pos < held && held_keys[pos] >= key)
					pos++;
				for (int i = held; i > pos; i--)
					held_keys[i] = held_keys[i-1];
				held_keys[pos] = key;
				held++;
			end
		end else if (held == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.taken = held_keys[0];
			for (int i = 1; i < held; i++)
				held_keys[i-1] = held_keys[i];
			held--;
		end
		r.fill = FillW'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			held = 0;
			expected_q.delete();
			fail_count   = 0;
			pending      = 0;
			result_count = 0;
			full_count   = 0;
			empty_count  = 0;
		end else begin
			// an output transfer always belongs to an earlier input transfer
			if (m_tvalid && m_tready) begin
				result_count++;
				if (expected_q.size() == 0) begin
					fail_count++;
					$error("result with no item pending: status %0d, data %h", m_tuser, m_tdata);
				end else begin
					want = expected_q.pop_front();
					if (m_tuser !== want.status) begin
						fail_count++;
						$error("status: expected %0d, actual %0d", want.status, m_tuser);
					end
					if (m_tdata[15:0] !== want.taken) begin
						fail_count++;
						$error("removed_value: expected %h, actual %h", want.taken, m_tdata[15:0]);
					end
					if (m_tdata[20:16] !== want.fill) begin
						fail_count++;
						$error("fill_level: expected %0d, actual %0d", want.fill, m_tdata[20:16]);
					end
					if (m_tdata[23:21] !== 3'b000) begin
						fail_count++;
						$error("pad: expected 0, actual %b", m_tdata[23:21]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = apply_item(spq_mode_t'(s_tuser), s_tdata);
				if (want.status == ST_FULL)
					full_count++;
				if (want.status == ST_EMPTY)
					empty_count++;
				expected_q.push_back(want);
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- tb/sorted_priority_queue_unit_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the sorted priority queue unit.
module sorted_priority_queue_unit_tb
	import spq_pkg::*;
();

	localparam int CycleLimit = 60000;
	localparam int HoldCycles = 80;
	localparam int Bursts     = 12;
	localparam int BurstLen   = 50;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	int fail_count;
	int pending;
	int result_count;
	int full_count;
	int empty_count;

	int src_idle_pct  = 36;
	int sink_idle_pct = 36;
	bit hold_req      = 1'b0;
	int cycle         = 0;

	// insert bias per burst, in percent: swings the queue between empty and full
	int insert_bias [Bursts] = '{80, 50, 20, 95, 50, 5, 60, 40, 90, 10, 50, 50};

	sorted_priority_queue_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spq_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.full_count   (full_count),
		.empty_count  (empty_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle++;
		if (cycle >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle, pending);
			$display("sorted_priority_queue_unit_tb: done, errors");
			$finish;
		end
	end

	// Favor keys that collide or sit at the edges of the range.
	function automatic logic [KeyW-1:0] pick_key();
		case ($urandom_range(4))
			0: begin
				return KeyW'($urandom_range(7));
			end
			1: begin
				return 16'hFFFF - KeyW'($urandom_range(3));
			end
			2: begin
				return 16'h8000 ^ KeyW'($urandom_range(3));
			end
			default: begin
				return KeyW'($urandom);
			end
		endcase
	endfunction

	// Offer one item at the falling edge and hold it until the transfer.
	task automatic send_item(input spq_mode_t mode, input logic [KeyW-1:0] key);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = KeyW'($urandom);
			s_tuser  = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = key;
		s_tuser  = mode;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 1'b0;
			end
			m_tready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		int        b;
		int        n;
		spq_mode_t mode;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_INSERT;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// remove from empty, then fill with edge keys and a tie
		send_item(MODE_REMOVE, 16'hFFFF);
		send_item(MODE_INSERT, 16'h0000);
		send_item(MODE_INSERT, 16'hFFFF);
		send_item(MODE_INSERT, 16'h8000);
		send_item(MODE_INSERT, 16'h7FFF);
		send_item(MODE_INSERT, 16'h1234);
		send_item(MODE_INSERT, 16'h1234);
		send_item(MODE_INSERT, 16'h0001);
		send_item(MODE_INSERT, 16'hFFFE);
		send_item(MODE_INSERT, 16'h5555);
		send_item(MODE_INSERT, 16'hAAAA);
		for (n = 0; n < 6; n++)
			send_item(MODE_INSERT, pick_key());
		// queue is full now: both inserts are refused
		send_item(MODE_INSERT, 16'hFFFF);
		send_item(MODE_INSERT, 16'h0000);
		send_item(MODE_REMOVE, 16'h0000);
		send_item(MODE_REMOVE, 16'hFFFF);
		send_item(MODE_REMOVE, KeyW'($urandom));

		for (b = 0; b < Bursts; b++) begin
			if (b == 3)
				hold_req = 1'b1;
			if (b == 7) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end else begin
				src_idle_pct  = 36;
				sink_idle_pct = 36;
			end
			for (n = 0; n < BurstLen; n++) begin
				mode = ($urandom_range(99) < insert_bias[b]) ? MODE_INSERT : MODE_REMOVE;
				send_item(mode, (mode == MODE_INSERT) ? pick_key() : KeyW'($urandom));
			end
		end
		s_tvalid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("checked %0d results in %0d cycles: %0d refused inserts, %0d empty removes",
		         result_count, cycle, full_count, empty_count);
		$display("covered ties, key extremes, a long output stall and a burst without gaps");
		if (fail_count == 0)
			$display("sorted_priority_queue_unit_tb: done, clean");
		else
			$display("sorted_priority_queue_unit_tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_unit.sv
tb/spq_checker.sv
tb/sorted_priority_queue_unit_tb.sv
